[sv/psq_pkg.sv]
// package for the priority select queue
// holds item and result structs, operation and status codes, controller states
// depended on by psq_cell and priority_select_queue

package psq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ID_W      = 16;
	localparam int PRI_W     = 8;
	localparam int BIT_W     = $clog2(PRI_W);
	localparam int OCC_W     = 5;

	typedef enum logic [1:0] {
		OP_ENQUEUE     = 2'd0,
		OP_DEQ_OLDEST  = 2'd1,
		OP_DEQ_HIGHEST = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_SHIFT
	} psq_state_t;

	typedef struct packed {
		op_t              operation;
		logic [ID_W-1:0]  proc_id;
		logic [PRI_W-1:0] priority_in;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  out_id;
		logic [PRI_W-1:0] out_priority;
		logic [OCC_W-1:0] occupancy;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
	} entry_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic             write_en;
		entry_t           wr_entry;
		logic             init_all;
		logic             init_first;
		logic             scan;
		logic             scan_any;
		logic [BIT_W-1:0] bit_idx;
		logic             pick;
		logic             shift;
	} cell_ctrl_t;

endpackage

[sv/psq_cell.sv]
// one storage cell of the priority select queue row
// holds an entry plus candidate and shift flags, chained to its neighbours
// depends on psq_pkg

module psq_cell #(
	parameter int CW    = 5,
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  psq_pkg::cell_ctrl_t ctrl,
	input  logic [CW-1:0]       count,
	input  psq_pkg::entry_t     next_entry,
	input  logic                before_in,
	output logic                before_out,
	output logic                scan_bit,
	output psq_pkg::entry_t     entry,
	output psq_pkg::entry_t     sel_entry
);

	psq_pkg::entry_t ent_q;
	logic            alive_q;
	logic            shift_q;
	logic            occ;

	assign occ        = CW'(INDEX) < count;
	assign scan_bit   = alive_q & ent_q.pri[ctrl.bit_idx];
	assign before_out = before_in | alive_q;
	assign entry      = ent_q;
	assign sel_entry  = alive_q ? ent_q : '0;

	// entry payload, no reset
	always_ff @(posedge clk) begin
		if (ctrl.write_en && count == CW'(INDEX)) begin
			ent_q <= ctrl.wr_entry;
		end else if (ctrl.shift && shift_q) begin
			ent_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
			shift_q <= 1'b0;
		end else begin
			if (ctrl.init_all) begin
				alive_q <= occ;
			end else if (ctrl.init_first) begin
				alive_q <= (INDEX == 0);
			end else if (ctrl.scan) begin
				// drop candidates lacking this bit when some candidate has it
				if (ctrl.scan_any) begin
					alive_q <= scan_bit;
				end
			end else if (ctrl.pick) begin
				// keep only the oldest remaining candidate
				alive_q <= alive_q & ~before_in;
				shift_q <= before_in | alive_q;
			end
		end
	end

endmodule

[sv/priority_select_queue.sv]
// top level of the priority select queue: sequencer and row of storage cells
// depends on psq_pkg and psq_cell

// Command-driven queue of up to DEPTH (identifier, priority) entries kept in
// arrival order, cell 0 holding the oldest. A command transfer happens on a
// clock edge with start high and busy low; each command gives exactly one
// result, shown on result for a single cycle with done high. The receiver
// cannot hold results off, so capture result whenever done is high.
// Timing: enqueue and the unused operation code never leave idle, so busy never
// rises and the result appears the cycle after the transfer. Dequeue of the
// oldest entry passes through pick, then shift of the row. Dequeue of the
// highest priority passes through scan, pick and shift: the maximum is found one
// priority bit per cycle, most significant first, by a wide OR over the
// candidate flags of all cells; then the oldest surviving candidate is picked
// along the cell chain and the row behind it closes up by one cell.
// Dequeue on an empty queue and enqueue on a full one also answer from idle.
// occupancy is the entry count after the command, truncated to five bits.

module priority_select_queue #(
	parameter int DEPTH = psq_pkg::DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  psq_pkg::item_t   cmd,
	output logic             done,
	output psq_pkg::result_t result
);

	localparam int CW = $clog2(DEPTH + 1);

	psq_pkg::psq_state_t state_q, state_d;
	logic [psq_pkg::BIT_W-1:0] bit_q, bit_d;
	logic [CW-1:0]             count_q, count_d;
	logic                      done_q, done_d;
	psq_pkg::result_t          result_q, result_d;
	psq_pkg::cell_ctrl_t       ctrl;

	// chain wiring between cells
	logic [DEPTH:0]            before_w;
	logic [DEPTH-1:0]          scan_bits;
	psq_pkg::entry_t           entry_w   [DEPTH];
	psq_pkg::entry_t           sel_w     [DEPTH];
	psq_pkg::entry_t           sel_entry;
	logic                      full;

	assign busy   = (state_q != psq_pkg::S_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign full   = (count_q == CW'(DEPTH));

	assign before_w[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			psq_pkg::entry_t nxt;
			if (gi == DEPTH - 1) begin : g_last
				assign nxt = '0;
			end else begin : g_mid
				assign nxt = entry_w[gi+1];
			end
			psq_cell #(
				.CW    (CW),
				.INDEX (gi)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.count      (count_q),
				.next_entry (nxt),
				.before_in  (before_w[gi]),
				.before_out (before_w[gi+1]),
				.scan_bit   (scan_bits[gi]),
				.entry      (entry_w[gi]),
				.sel_entry  (sel_w[gi])
			);
		end
	endgenerate

	// the selected cell is one-hot during shift, so an OR gathers it
	always_comb begin
		sel_entry = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_entry = sel_entry | sel_w[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psq_pkg::S_IDLE;
			bit_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			bit_q   <= bit_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (done_d) begin
			result_q <= result_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		bit_d    = bit_q;
		count_d  = count_q;
		done_d   = 1'b0;
		result_d = '0;
		result_d.status    = psq_pkg::ST_OK;
		result_d.occupancy = psq_pkg::OCC_W'(count_q);

		ctrl            = '0;
		ctrl.wr_entry   = '{id: cmd.proc_id, pri: cmd.priority_in};
		ctrl.bit_idx    = bit_q;
		ctrl.scan_any   = |scan_bits;

		case (state_q)
			psq_pkg::S_IDLE: begin
				if (start) begin
					case (cmd.operation)
						psq_pkg::OP_ENQUEUE: begin
							done_d = 1'b1;
							if (full) begin
								result_d.status = psq_pkg::ST_OVERFLOW;
							end else begin
								// tail cell takes the new entry
								ctrl.write_en      = 1'b1;
								count_d            = CW'(count_q + 1'b1);
								result_d.occupancy = psq_pkg::OCC_W'(count_d);
							end
						end
						psq_pkg::OP_DEQ_OLDEST: begin
							if (count_q == '0) begin
								done_d          = 1'b1;
								result_d.status = psq_pkg::ST_UNDERFLOW;
							end else begin
								ctrl.init_first = 1'b1;
								state_d         = psq_pkg::S_PICK;
							end
						end
						psq_pkg::OP_DEQ_HIGHEST: begin
							if (count_q == '0) begin
								done_d          = 1'b1;
								result_d.status = psq_pkg::ST_UNDERFLOW;
							end else begin
								// every held entry starts as a candidate
								ctrl.init_all = 1'b1;
								bit_d         = psq_pkg::BIT_W'(psq_pkg::PRI_W - 1);
								state_d       = psq_pkg::S_SCAN;
							end
						end
						default: begin
							// unused code: no change, report current count
							done_d = 1'b1;
						end
					endcase
				end
			end
			psq_pkg::S_SCAN: begin
				// one priority bit per cycle, most significant first
				ctrl.scan = 1'b1;
				bit_d     = bit_q - 1'b1;
				if (bit_q == '0) begin
					state_d = psq_pkg::S_PICK;
				end
			end
			psq_pkg::S_PICK: begin
				// oldest candidate found along the before chain
				ctrl.pick = 1'b1;
				state_d   = psq_pkg::S_SHIFT;
			end
			psq_pkg::S_SHIFT: begin
				// hand out the picked entry and close the gap behind it
				ctrl.shift            = 1'b1;
				count_d               = count_q - 1'b1;
				done_d                = 1'b1;
				result_d.out_id       = sel_entry.id;
				result_d.out_priority = sel_entry.pri;
				result_d.occupancy    = psq_pkg::OCC_W'(count_d);
				state_d               = psq_pkg::S_IDLE;
			end
			default: begin
				state_d = psq_pkg::S_IDLE;
			end
		endcase
	end

endmodule
